/* rtl/core/bbc_pkg.sv */
package bbc_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int FILL_W      = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);

	localparam int OPQ_DEPTH  = 2;
	localparam int OPQ_PTR_W  = $clog2(OPQ_DEPTH);
	localparam int OPQ_CNT_W  = $clog2(OPQ_DEPTH + 1);

	localparam int RESQ_DEPTH = 2;
	localparam int RESQ_PTR_W = $clog2(RESQ_DEPTH);
	localparam int RESQ_CNT_W = $clog2(RESQ_DEPTH + 1);

	localparam logic [7:0] CHAR_LPAREN   = 8'h28;
	localparam logic [7:0] CHAR_RPAREN   = 8'h29;
	localparam logic [7:0] CHAR_LBRACE   = 8'h7B;
	localparam logic [7:0] CHAR_RBRACE   = 8'h7D;
	localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
	localparam logic [7:0] CHAR_RBRACKET = 8'h5D;

	typedef enum logic [1:0] {
		KIND_PAREN   = 2'd0,
		KIND_BRACE   = 2'd1,
		KIND_BRACKET = 2'd2,
		KIND_NONE    = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       end_of_string;
	} in_item_t;

	typedef struct packed {
		logic is_balanced;
		logic depth_overflow;
	} out_item_t;

	typedef struct packed {
		logic  is_open;
		logic  is_close;
		kind_t kind;
		logic  last;
	} op_t;

endpackage

/* rtl/core/bbc_front.sv */
module bbc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  bbc_pkg::in_item_t  char_item,
	output logic               op_valid,
	output bbc_pkg::op_t       op,
	input  logic               op_take
);

	bbc_pkg::op_t                   cls;
	bbc_pkg::op_t                   opq_mem [bbc_pkg::OPQ_DEPTH];
	logic [bbc_pkg::OPQ_PTR_W-1:0]  wr_ptr_q;
	logic [bbc_pkg::OPQ_PTR_W-1:0]  rd_ptr_q;
	logic [bbc_pkg::OPQ_CNT_W-1:0]  cnt_q;
	logic                           wr_en;
	logic                           rd_en;

	// classify the byte
	always_comb begin
		cls.is_open  = 1'b0;
		cls.is_close = 1'b0;
		cls.kind     = bbc_pkg::KIND_NONE;
		cls.last     = char_item.end_of_string;
		case (char_item.char_byte)
			bbc_pkg::CHAR_LPAREN: begin
				cls.is_open = 1'b1;
				cls.kind    = bbc_pkg::KIND_PAREN;
			end
			bbc_pkg::CHAR_LBRACE: begin
				cls.is_open = 1'b1;
				cls.kind    = bbc_pkg::KIND_BRACE;
			end
			bbc_pkg::CHAR_LBRACKET: begin
				cls.is_open = 1'b1;
				cls.kind    = bbc_pkg::KIND_BRACKET;
			end
			bbc_pkg::CHAR_RPAREN: begin
				cls.is_close = 1'b1;
				cls.kind     = bbc_pkg::KIND_PAREN;
			end
			bbc_pkg::CHAR_RBRACE: begin
				cls.is_close = 1'b1;
				cls.kind     = bbc_pkg::KIND_BRACE;
			end
			bbc_pkg::CHAR_RBRACKET: begin
				cls.is_close = 1'b1;
				cls.kind     = bbc_pkg::KIND_BRACKET;
			end
			default: begin
				cls.kind = bbc_pkg::KIND_NONE;
			end
		endcase
	end

	assign full     = (cnt_q == bbc_pkg::OPQ_CNT_W'(bbc_pkg::OPQ_DEPTH));
	assign op_valid = (cnt_q != '0);
	assign wr_en    = push && !full;
	assign rd_en    = op_take && op_valid;
	assign op       = opq_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			opq_mem[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				if (wr_ptr_q == bbc_pkg::OPQ_PTR_W'(bbc_pkg::OPQ_DEPTH - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + 1'b1;
				end
			end
			if (rd_en) begin
				if (rd_ptr_q == bbc_pkg::OPQ_PTR_W'(bbc_pkg::OPQ_DEPTH - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
				end
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/core/bbc_stack.sv */
module bbc_stack (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                op_valid,
	input  bbc_pkg::op_t        op,
	output logic                op_take,
	input  logic                res_full,
	output logic                res_push,
	output bbc_pkg::out_item_t  res
);

	// top entry lives in top_q, the rest in stack_mem[0 .. fill-2]
	logic [1:0]                  stack_mem [bbc_pkg::STACK_DEPTH];
	logic [1:0]                  top_q;
	logic [bbc_pkg::FILL_W-1:0]  fill_q;
	logic                        mismatch_q;
	logic                        overflow_q;
	logic [1:0]                  rd_q;
	logic                        byp_q;
	logic [1:0]                  byp_data_q;

	logic                        active;
	logic                        do_push;
	logic                        do_pop;
	logic                        set_mismatch;
	logic                        set_overflow;
	logic [bbc_pkg::FILL_W-1:0]  fill_d;
	logic [bbc_pkg::FILL_W-1:0]  raddr_full;
	logic [bbc_pkg::FILL_W-1:0]  waddr_full;
	logic                        mem_we;
	logic [1:0]                  second;
	logic                        mismatch_d;
	logic                        overflow_d;

	assign op_take = op_valid && (!op.last || !res_full);
	assign active  = op_take && !mismatch_q && !overflow_q;

	always_comb begin
		do_push      = 1'b0;
		do_pop       = 1'b0;
		set_mismatch = 1'b0;
		set_overflow = 1'b0;
		if (active && op.is_open) begin
			if (fill_q == bbc_pkg::FILL_W'(bbc_pkg::STACK_DEPTH)) begin
				set_overflow = 1'b1;
			end else begin
				do_push = 1'b1;
			end
		end else if (active && op.is_close) begin
			if (fill_q != '0 && top_q == op.kind) begin
				do_pop = 1'b1;
			end else begin
				set_mismatch = 1'b1;
			end
		end
	end

	assign mismatch_d = mismatch_q || set_mismatch;
	assign overflow_d = overflow_q || set_overflow;

	always_comb begin
		fill_d = fill_q;
		if (do_push) begin
			fill_d = fill_q + 1'b1;
		end else if (do_pop) begin
			fill_d = fill_q - 1'b1;
		end
	end

	// keep the entry below the top prefetched
	assign raddr_full = fill_d - bbc_pkg::FILL_W'(2);
	assign waddr_full = fill_q - bbc_pkg::FILL_W'(1);
	assign mem_we     = do_push && (fill_q != '0);
	assign second     = byp_q ? byp_data_q : rd_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[waddr_full[bbc_pkg::ADDR_W-1:0]] <= top_q;
		end
		rd_q       <= stack_mem[raddr_full[bbc_pkg::ADDR_W-1:0]];
		byp_data_q <= top_q;
		if (do_push) begin
			top_q <= op.kind;
		end else if (do_pop) begin
			top_q <= second;
		end
	end

	assign res_push           = op_take && op.last;
	assign res.is_balanced    = !mismatch_d && !overflow_d && (fill_d == '0);
	assign res.depth_overflow = overflow_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			mismatch_q <= 1'b0;
			overflow_q <= 1'b0;
			byp_q      <= 1'b0;
		end else begin
			byp_q <= mem_we;
			if (res_push) begin
				// drop the string state after its last byte
				fill_q     <= '0;
				mismatch_q <= 1'b0;
				overflow_q <= 1'b0;
			end else begin
				fill_q     <= fill_d;
				mismatch_q <= mismatch_d;
				overflow_q <= overflow_d;
			end
		end
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= bbc_pkg::FILL_W'(bbc_pkg::STACK_DEPTH))
		else $error("stack fill beyond depth");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |=> (fill_q == '0) && !mismatch_q && !overflow_q)
		else $error("state not cleared after last byte");

	a_result_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !(res.is_balanced && res.depth_overflow))
		else $error("balanced result with overflow");

	a_overflow_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(set_overflow && !op.last) |=> overflow_q && $stable(fill_q))
		else $error("overflow push changed stack");
`endif

endmodule

/* rtl/core/bbc_out_queue.sv */
module bbc_out_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                res_push,
	input  bbc_pkg::out_item_t  res,
	output logic                res_full,
	input  logic                pop,
	output logic                empty,
	output bbc_pkg::out_item_t  result
);

	bbc_pkg::out_item_t              resq_mem [bbc_pkg::RESQ_DEPTH];
	logic [bbc_pkg::RESQ_PTR_W-1:0]  wr_ptr_q;
	logic [bbc_pkg::RESQ_PTR_W-1:0]  rd_ptr_q;
	logic [bbc_pkg::RESQ_CNT_W-1:0]  cnt_q;
	logic                            wr_en;
	logic                            rd_en;

	assign res_full = (cnt_q == bbc_pkg::RESQ_CNT_W'(bbc_pkg::RESQ_DEPTH));
	assign empty    = (cnt_q == '0);
	assign wr_en    = res_push && !res_full;
	assign rd_en    = pop && !empty;
	assign result   = resq_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			resq_mem[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				if (wr_ptr_q == bbc_pkg::RESQ_PTR_W'(bbc_pkg::RESQ_DEPTH - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + 1'b1;
				end
			end
			if (rd_en) begin
				if (rd_ptr_q == bbc_pkg::RESQ_PTR_W'(bbc_pkg::RESQ_DEPTH - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
				end
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/core/bracket_balance_checker_unit.sv */
// Balanced-bracket checker over a byte stream, one byte per item.
// Input queue side: drive char_item and raise push; the item is taken on a
// clock edge with push high and full low. Set end_of_string on the final
// byte of each string (an empty string is one ignored byte with it set).
// Result queue side: while empty is low, result holds the verdict of the
// oldest finished string; it is taken on an edge with pop high.
// Throughput: one byte per cycle while the result queue has room, set by
// the single stack-top update per cycle; the top entry is held in a
// register and the entry below it is prefetched from the stack memory, so
// push, pop and compare never wait. A last byte is registered in the byte
// queue, checked by the stack engine as it leaves that queue, and its
// verdict is registered in the result queue, from which it can be popped.
// When pop stays low the result queue fills, the stack engine holds at the
// next last byte, the byte queue fills and full rises; nothing is dropped.
// Reset empties both queues and clears the stack fill and the sticky error
// flags; the stack memory itself is not cleared and needs no sweep.
module bracket_balance_checker_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  bbc_pkg::in_item_t   char_item,
	output logic                empty,
	input  logic                pop,
	output bbc_pkg::out_item_t  result
);

	logic                op_valid;
	bbc_pkg::op_t        op;
	logic                op_take;
	logic                res_full;
	logic                res_push;
	bbc_pkg::out_item_t  res;

	bbc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.char_item (char_item),
		.op_valid  (op_valid),
		.op        (op),
		.op_take   (op_take)
	);

	bbc_stack u_stack (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op       (op),
		.op_take  (op_take),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res)
	);

	bbc_out_queue u_out_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res      (res),
		.res_full (res_full),
		.pop      (pop),
		.empty    (empty),
		.result   (result)
	);

endmodule
